>>> design/occupancy_grid_neighbor_engine_core_macros.svh
// ---------------------------------------------------------------------------
// Occupancy grid neighbour engine: assertion macros
// Shared assertion shorthands, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_NEIGHBOR_ENGINE_CORE_MACROS_SVH
`define OCCUPANCY_GRID_NEIGHBOR_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define OGNE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OGNE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ogne_pkg.sv
// ---------------------------------------------------------------------------
// ogne_pkg
// Types, codes and the neighbour action table of the occupancy grid engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ogne_pkg;

    typedef logic signed [15:0] t_cell;
    typedef logic [2:0]         t_cfg_index;

    // Clamp limits handed to the cell update unit.
    typedef struct packed {
        t_cell floor_val;
        t_cell ceil_val;
    } t_clamp;

    // Operation codes carried in func.
    localparam logic [1:0] FUNC_MARK  = 2'd0;
    localparam logic [1:0] FUNC_DECAY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_index CFG_THRESHOLD = 3'd0;
    localparam t_cfg_index CFG_FLOOR     = 3'd1;
    localparam t_cfg_index CFG_CEILING   = 3'd2;
    localparam t_cfg_index CFG_FREE      = 3'd3;
    localparam t_cfg_index CFG_DIAGONAL  = 3'd4;
    localparam t_cfg_index CFG_COST_AXIS = 3'd5;
    localparam t_cfg_index CFG_COST_DIAG = 3'd6;

    // Number of actions in each mode.
    localparam logic [3:0] ACT_COUNT8 = 4'd8;
    localparam logic [3:0] ACT_COUNT4 = 4'd4;

    // Action table as (row, column) offsets.
    localparam logic signed [1:0] ACT8_DX [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                  2'sd0, -2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] ACT8_DY [8] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                                  2'sd1, 2'sd1, 2'sd0, -2'sd1};
    localparam logic signed [1:0] ACT4_DX [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
    localparam logic signed [1:0] ACT4_DY [4] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};

    function automatic logic signed [1:0] act_dx(input logic diag, input logic [2:0] k);
        return diag ? ACT8_DX[k] : ACT4_DX[k[1:0]];
    endfunction

    function automatic logic signed [1:0] act_dy(input logic diag, input logic [2:0] k);
        return diag ? ACT8_DY[k] : ACT4_DY[k[1:0]];
    endfunction

    // A move is diagonal when both offsets are non-zero.
    function automatic logic act_is_diag(input logic diag, input logic [2:0] k);
        return (act_dx(diag, k) != 2'sd0) && (act_dy(diag, k) != 2'sd0);
    endfunction

    // Neighbour coordinate, range -1 to 128.
    function automatic logic signed [8:0] coord_step(input logic [6:0] c,
                                                     input logic signed [1:0] d);
        return $signed({2'b00, c}) + $signed({{7{d[1]}}, d});
    endfunction

endpackage

`default_nettype wire

>>> design/ogne_if.sv
// ---------------------------------------------------------------------------
// ogne_if
// Valid/ready channels for commands into and results out of the engine.
// ---------------------------------------------------------------------------
`default_nettype none

interface ogne_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic signed [15:0] confidence;

    modport source (output valid, func, cell_x, cell_y, confidence, input ready);
    modport sink   (input valid, func, cell_x, cell_y, confidence, output ready);
endinterface

interface ogne_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [6:0]  neighbor_x;
    logic [6:0]  neighbor_y;
    logic [2:0]  action_index;
    logic [15:0] step_cost;
    logic        last;

    modport source (output valid, found, neighbor_x, neighbor_y, action_index,
                    step_cost, last, input ready);
    modport sink   (input valid, found, neighbor_x, neighbor_y, action_index,
                    step_cost, last, output ready);
endinterface

`default_nettype wire

>>> design/ogne_ram.sv
// ---------------------------------------------------------------------------
// ogne_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module ogne_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, with registered data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/ogne_cell_upd.sv
// ---------------------------------------------------------------------------
// ogne_cell_upd
// Adds a signed increment to one cell and clamps the sum to the limits.
// ---------------------------------------------------------------------------
`default_nettype none

module ogne_cell_upd (
    input  wire ogne_pkg::t_cell     i_cell,
    input  wire logic signed [16:0]  i_addend,
    input  wire ogne_pkg::t_clamp    i_clamp,
    output ogne_pkg::t_cell          o_cell
);
    import ogne_pkg::*;

    logic signed [17:0] w_sum;
    logic signed [17:0] w_ceil;
    logic signed [17:0] w_floor;
    logic signed [17:0] w_hi;

    // Full-precision sum, so nothing wraps before the clamp.
    assign w_sum   = $signed({{2{i_cell[15]}}, i_cell}) + $signed({i_addend[16], i_addend});
    assign w_ceil  = $signed({{2{i_clamp.ceil_val[15]}}, i_clamp.ceil_val});
    assign w_floor = $signed({{2{i_clamp.floor_val[15]}}, i_clamp.floor_val});

    // Ceiling first, then floor: an inverted pair yields the floor.
    assign w_hi = (w_sum > w_ceil) ? w_ceil : w_sum;

    always_comb begin
        if (w_hi < w_floor) begin
            o_cell = i_clamp.floor_val;
        end else begin
            o_cell = w_hi[15:0];
        end
    end

endmodule

`default_nettype wire

>>> design/occupancy_grid_neighbor_engine_core.sv
// Mark: an in-range cell is read, then written back, and the result follows.
// Neighbour query: one memory read per action through the single grid read port, then
// one result per cycle while the result side does not stall.
// Decay and clear sweep the grid at one cell a cycle, then return one result.
// After reset a clearing pass zeroes the grid; commands wait for it to end, configuration
// writes do not.
// ---------------------------------------------------------------------------
// occupancy_grid_neighbor_engine_core
// Log-odds occupancy grid in one memory with mark, decay, clear and
// neighbour query commands.
// ---------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_neighbor_engine_core #(
    parameter int GRID_SIDE = 128
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    ogne_in_if.sink                     i_cmd,
    ogne_out_if.source                  o_res,
    input  wire logic                   i_cfg_we,
    input  wire ogne_pkg::t_cfg_index   i_cfg_index,
    input  wire logic [15:0]            i_cfg_wdata
);
    import ogne_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
    localparam logic [11:0]   SIDE_U = 12'(GRID_SIDE);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CLEAR   = 4'd2;
    localparam logic [3:0] S_DECAY   = 4'd3;
    localparam logic [3:0] S_MARK_RD = 4'd4;
    localparam logic [3:0] S_MARK_WR = 4'd5;
    localparam logic [3:0] S_SCAN    = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;
    localparam logic [3:0] S_ACK     = 4'd8;

    // Configuration registers.
    t_cell       r_thr;
    t_cell       r_floor;
    t_cell       r_ceil;
    t_cell       r_free;
    logic        r_diag;
    logic [15:0] r_cost_s;
    logic [15:0] r_cost_d;

    // Control state.
    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [AW-1:0] r_sweep;
    logic          r_rd_done;
    logic          r_wb_valid;
    logic [AW-1:0] r_wb_addr;
    logic [3:0]    r_k;
    logic          r_ev_valid;
    logic [2:0]    r_ev_k;
    logic          r_ev_inb;
    logic [7:0]    r_mask;

    // Current command payload.
    logic [6:0]         r_cx;
    logic [6:0]         r_cy;
    logic               r_inside;
    logic [AW-1:0]      r_addr;
    logic signed [16:0] r_addend;

    // Output register.
    logic        r_out_valid;
    logic        r_out_found;
    logic [6:0]  r_out_x;
    logic [6:0]  r_out_y;
    logic [2:0]  r_out_act;
    logic [15:0] r_out_cost;
    logic        r_out_last;

    logic               w_accept;
    logic               w_inside;
    logic [3:0]         w_count;
    logic signed [8:0]  w_scan_nx;
    logic signed [8:0]  w_scan_ny;
    logic               w_scan_inb;
    logic [AW-1:0]      w_scan_addr;
    logic               w_scan_issue;
    logic [7:0]         w_pick_oh;
    logic [2:0]         w_pick_idx;
    logic signed [8:0]  w_pick_nx;
    logic signed [8:0]  w_pick_ny;
    logic               w_pick_last;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [15:0]        w_ram_wdata;
    logic [AW-1:0]      w_ram_raddr;
    logic [15:0]        w_ram_rdata;
    logic signed [16:0] w_upd_addend;
    t_clamp             w_clamp;
    t_cell              w_upd_cell;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= 16'sd0;
            r_floor  <= -16'sd4096;
            r_ceil   <= 16'sd4096;
            r_free   <= -16'sd512;
            r_diag   <= 1'b1;
            r_cost_s <= 16'd256;
            r_cost_d <= 16'd362;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr    <= i_cfg_wdata;
                CFG_FLOOR:     r_floor  <= i_cfg_wdata;
                CFG_CEILING:   r_ceil   <= i_cfg_wdata;
                CFG_FREE:      r_free   <= i_cfg_wdata;
                CFG_DIAGONAL:  r_diag   <= i_cfg_wdata[0];
                CFG_COST_AXIS: r_cost_s <= i_cfg_wdata;
                CFG_COST_DIAG: r_cost_d <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Command intake: one transaction at a time, taken only when idle.
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign w_inside    = ({5'b0, i_cmd.cell_x} < SIDE_U) && ({5'b0, i_cmd.cell_y} < SIDE_U);
    assign w_count     = r_diag ? ACT_COUNT8 : ACT_COUNT4;

    // Neighbour address for the action being scanned.
    assign w_scan_nx    = coord_step(r_cx, act_dx(r_diag, r_k[2:0]));
    assign w_scan_ny    = coord_step(r_cy, act_dy(r_diag, r_k[2:0]));
    assign w_scan_inb   = r_inside
                          && !w_scan_nx[8] && ({3'b0, w_scan_nx} < SIDE_U)
                          && !w_scan_ny[8] && ({3'b0, w_scan_ny} < SIDE_U);
    assign w_scan_addr  = AW'(w_scan_nx[7:0]) * SIDE_A + AW'(w_scan_ny[7:0]);
    assign w_scan_issue = (r_state == S_SCAN) && (r_k != w_count);

    // Lowest qualifying action still to be sent.
    assign w_pick_oh = r_mask & (~r_mask + 8'd1);
    always_comb begin
        w_pick_idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (w_pick_oh[i]) begin
                w_pick_idx = 3'(i);
            end
        end
    end
    assign w_pick_nx   = coord_step(r_cx, act_dx(r_diag, w_pick_idx));
    assign w_pick_ny   = coord_step(r_cy, act_dy(r_diag, w_pick_idx));
    assign w_pick_last = ((r_mask & ~w_pick_oh) == 8'd0);

    // The output register can take a result when empty or being drained.
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_out_load = w_out_free && ((r_state == S_ACK) || (r_state == S_EMIT));

    // Memory port selection.
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = w_upd_cell;
        w_ram_raddr = r_addr;
        case (r_state)
            S_INIT, S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_sweep;
                w_ram_wdata = 16'd0;
            end
            S_DECAY: begin
                w_ram_we    = r_wb_valid;
                w_ram_waddr = r_wb_addr;
                w_ram_raddr = r_sweep;
            end
            S_MARK_WR: begin
                w_ram_we = 1'b1;
            end
            S_SCAN: begin
                w_ram_raddr = w_scan_addr;
            end
            default: begin
            end
        endcase
    end

    ogne_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Cell update: decay adds the free log-odds, mark adds the stored increment.
    assign w_upd_addend    = (r_state == S_DECAY) ? $signed({r_free[15], r_free}) : r_addend;
    assign w_clamp.floor_val = r_floor;
    assign w_clamp.ceil_val  = r_ceil;

    ogne_cell_upd u_upd (
        .i_cell   (w_ram_rdata),
        .i_addend (w_upd_addend),
        .i_clamp  (w_clamp),
        .o_cell   (w_upd_cell)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_sweep == LAST_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.func)
                        FUNC_MARK:  n_state = w_inside ? S_MARK_RD : S_ACK;
                        FUNC_DECAY: n_state = S_DECAY;
                        FUNC_CLEAR: n_state = S_CLEAR;
                        FUNC_QUERY: n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_sweep == LAST_A) begin
                    n_state = S_ACK;
                end
            end
            S_DECAY: begin
                if (r_rd_done) begin
                    n_state = S_ACK;
                end
            end
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: n_state = S_ACK;
            S_SCAN: begin
                if (r_k == w_count) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && ((r_mask == 8'd0) || w_pick_last)) begin
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_rd_done   <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_k         <= 4'd0;
            r_ev_valid  <= 1'b0;
            r_mask      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Sweep counter for clearing and decay.
            if (w_accept) begin
                r_sweep   <= '0;
                r_rd_done <= 1'b0;
            end else if ((r_state == S_INIT) || (r_state == S_CLEAR)
                         || ((r_state == S_DECAY) && !r_rd_done)) begin
                r_sweep <= r_sweep + AW'(1);
                if (r_sweep == LAST_A) begin
                    r_rd_done <= 1'b1;
                end
            end

            // Decay writes each cell back in the cycle after its read.
            r_wb_valid <= (r_state == S_DECAY) && !r_rd_done;

            // Query scan: issue one read per action and test its data in the following cycle.
            if (w_accept) begin
                r_k        <= 4'd0;
                r_ev_valid <= 1'b0;
                r_mask     <= 8'd0;
            end else begin
                r_ev_valid <= w_scan_issue;
                if (w_scan_issue) begin
                    r_k <= r_k + 4'd1;
                end
                if (r_ev_valid && r_ev_inb && ($signed(w_ram_rdata) < r_thr)) begin
                    r_mask[r_ev_k] <= 1'b1;
                end
                if ((r_state == S_EMIT) && w_out_load) begin
                    r_mask <= r_mask & ~w_pick_oh;
                end
            end

            // Output handshake.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cx     <= i_cmd.cell_x;
            r_cy     <= i_cmd.cell_y;
            r_inside <= w_inside;
            r_addr   <= AW'(i_cmd.cell_x) * SIDE_A + AW'(i_cmd.cell_y);
            r_addend <= $signed({i_cmd.confidence[15], i_cmd.confidence})
                        - $signed({r_free[15], r_free});
        end
        r_wb_addr <= r_sweep;
        r_ev_k    <= r_k[2:0];
        r_ev_inb  <= w_scan_inb;
        if (w_out_load) begin
            if ((r_state == S_EMIT) && (r_mask != 8'd0)) begin
                r_out_found <= 1'b1;
                r_out_x     <= w_pick_nx[6:0];
                r_out_y     <= w_pick_ny[6:0];
                r_out_act   <= w_pick_idx;
                r_out_cost  <= act_is_diag(r_diag, w_pick_idx) ? r_cost_d : r_cost_s;
                r_out_last  <= w_pick_last;
            end else begin
                r_out_found <= 1'b0;
                r_out_x     <= 7'd0;
                r_out_y     <= 7'd0;
                r_out_act   <= 3'd0;
                r_out_cost  <= 16'd0;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_out_found;
    assign o_res.neighbor_x   = r_out_x;
    assign o_res.neighbor_y   = r_out_y;
    assign o_res.action_index = r_out_act;
    assign o_res.step_cost    = r_out_cost;
    assign o_res.last         = r_out_last;

    // Design checks.
    `include "occupancy_grid_neighbor_engine_core_macros.svh"

    `OGNE_ASSERT_IMP(a_no_write_idle, (r_state == S_IDLE), !w_ram_we, "grid written while idle")
    `OGNE_ASSERT_IMP(a_load_free, w_out_load, (!r_out_valid || o_res.ready), "result overwritten")
    `OGNE_ASSERT_NXT(a_mask_step, ((r_state == S_EMIT) && w_out_load && (r_mask != 8'd0)), ($countones(r_mask) + 1 == $countones($past(r_mask))), "neighbour mask did not drop one action")

endmodule

`default_nettype wire

>>> sim/ogne_grid_checker.sv
// ---------------------------------------------------------------------------
// ogne_grid_checker
// Watches the command, result and configuration ports of the occupancy grid
// engine, keeps its own copy of the grid and settings, predicts the results
// of every accepted command and compares them with what the engine returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ogne_grid_checker
    import ogne_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ogne_in_if               i_cmd,
    ogne_out_if              i_res,
    input  wire logic        i_cfg_we,
    input  wire t_cfg_index  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    output int               o_mismatches,
    output int               o_outstanding
);

    localparam int SIDE         = 128;
    localparam int REPORT_LIMIT = 10;

    // Neighbour moves as (row, column) offsets, eight-way and four-way.
    localparam int ROW_STEP8 [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int COL_STEP8 [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    localparam int ROW_STEP4 [4] = '{0, 1, 0, -1};
    localparam int COL_STEP4 [4] = '{-1, 0, 1, 0};

    typedef struct packed {
        logic        found;
        logic [6:0]  nx;
        logic [6:0]  ny;
        logic [2:0]  act;
        logic [15:0] cost;
        logic        last;
    } t_grid_result;

    // Shadow grid and settings.
    logic signed [15:0] occ_grid [SIDE*SIDE];
    logic signed [15:0] blocked_level;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_hi;
    logic signed [15:0] free_obs;
    logic               diag_moves;
    logic [15:0]        axis_cost;
    logic [15:0]        diag_cost;

    t_grid_result awaited_results[$];
    int           mismatch_count = 0;
    int           awaited_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = awaited_count;

    // The ceiling is applied first, so an inverted pair settles on the floor.
    function automatic logic signed [15:0] clamp_log_odds(input int v);
        if (v > int'(clamp_hi)) v = clamp_hi;
        if (v < int'(clamp_lo)) v = clamp_lo;
        return 16'(v);
    endfunction

    // Appends one predicted result behind the ones already waiting.
    function automatic void add_expected(input t_grid_result r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    function automatic void predict_grid_command(input logic [1:0] func,
                                                 input logic [6:0] row,
                                                 input logic [6:0] col,
                                                 input logic signed [15:0] conf);
        int           idx;
        int           moves;
        int           hits;
        int           dr;
        int           dc;
        int           nr;
        int           nc;
        t_grid_result ack;
        t_grid_result nb;
        ack      = '0;
        ack.last = 1'b1;
        hits     = 0;
        case (func)
            FUNC_MARK: begin
                idx = int'(row) * SIDE + int'(col);
                occ_grid[idx] = clamp_log_odds(int'(occ_grid[idx]) + int'(conf)
                                               - int'(free_obs));
                add_expected(ack);
            end
            FUNC_DECAY: begin
                for (int i = 0; i < SIDE * SIDE; i++)
                    occ_grid[i] = clamp_log_odds(int'(occ_grid[i]) + int'(free_obs));
                add_expected(ack);
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < SIDE * SIDE; i++) occ_grid[i] = '0;
                add_expected(ack);
            end
            default: begin
                // Neighbour query: in-bounds cells below the blocking level,
                // in action order.
                moves = diag_moves ? 8 : 4;
                for (int k = 0; k < moves; k++) begin
                    if (diag_moves) begin
                        dr = ROW_STEP8[k];
                        dc = COL_STEP8[k];
                    end else begin
                        dr = ROW_STEP4[k];
                        dc = COL_STEP4[k];
                    end
                    nr = int'(row) + dr;
                    nc = int'(col) + dc;
                    if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE) begin
                        if (occ_grid[nr * SIDE + nc] < blocked_level) begin
                            nb.found = 1'b1;
                            nb.nx    = 7'(nr);
                            nb.ny    = 7'(nc);
                            nb.act   = 3'(k);
                            nb.cost  = (dr != 0 && dc != 0) ? diag_cost : axis_cost;
                            nb.last  = 1'b0;
                            add_expected(nb);
                            hits++;
                        end
                    end
                end
                if (hits == 0) begin
                    add_expected(ack);
                end else begin
                    nb      = awaited_results.pop_back();
                    nb.last = 1'b1;
                    add_expected(nb);
                end
            end
        endcase
    endfunction

    function automatic void report_result(input string what, input t_grid_result want,
                                          input t_grid_result seen);
        $display("%t %s: expected found=%0d x=%0d y=%0d act=%0d cost=%0d last=%0d,",
                 $realtime, what, want.found, want.nx, want.ny, want.act, want.cost,
                 want.last);
        $display("    got found=%0d x=%0d y=%0d act=%0d cost=%0d last=%0d",
                 seen.found, seen.nx, seen.ny, seen.act, seen.cost, seen.last);
    endfunction

    // Observe every port at the clock edge at which the engine samples it.
    always @(posedge i_clk) begin
        t_grid_result seen;
        t_grid_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE * SIDE; i++) occ_grid[i] = '0;
            blocked_level = 16'sd0;
            clamp_lo      = -16'sd4096;
            clamp_hi      = 16'sd4096;
            free_obs      = -16'sd512;
            diag_moves    = 1'b1;
            axis_cost     = 16'd256;
            diag_cost     = 16'd362;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: blocked_level = i_cfg_wdata;
                    CFG_FLOOR:     clamp_lo      = i_cfg_wdata;
                    CFG_CEILING:   clamp_hi      = i_cfg_wdata;
                    CFG_FREE:      free_obs      = i_cfg_wdata;
                    CFG_DIAGONAL:  diag_moves    = i_cfg_wdata[0];
                    CFG_COST_AXIS: axis_cost     = i_cfg_wdata;
                    CFG_COST_DIAG: diag_cost     = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_cmd.valid && i_cmd.ready)
                predict_grid_command(i_cmd.func, i_cmd.cell_x, i_cmd.cell_y,
                                     i_cmd.confidence);

            // Each result transaction is matched against the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                seen.found = i_res.found;
                seen.nx    = i_res.neighbor_x;
                seen.ny    = i_res.neighbor_y;
                seen.act   = i_res.action_index;
                seen.cost  = i_res.step_cost;
                seen.last  = i_res.last;
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        report_result("unexpected result", '0, seen);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            report_result("result mismatch", want, seen);
                    end
                end
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench of the occupancy grid engine: a directed opening on corners,
// edges and a fully free neighbourhood, then phases of random marks,
// queries, decays and clears under several register settings, with random
// gaps on the command side and random stalls on the result side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import ogne_pkg::*;

    // Index just past the register list; writes to it must be ignored.
    localparam t_cfg_index CFG_UNUSED = 3'd7;
    localparam int         MAX_IDLE   = 17;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    int mismatches;
    int outstanding;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int sweeps_left  = 12;
    int hot_x;
    int hot_y;

    ogne_in_if  cmd_ch ();
    ogne_out_if res_ch ();

    always #6 i_clk = ~i_clk;

    occupancy_grid_neighbor_engine_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ogne_grid_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Offers one command after a random gap and returns at the edge that
    // accepts it. Valid is only lowered when a gap is taken.
    task automatic send_command(input logic [1:0] func, input logic [6:0] row,
                                input logic [6:0] col, input logic signed [15:0] conf);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= func;
        cmd_ch.cell_x     <= row;
        cmd_ch.cell_y     <= col;
        cmd_ch.confidence <= conf;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic signed [15:0] thr,
                                 input logic signed [15:0] lo,
                                 input logic signed [15:0] hi,
                                 input logic signed [15:0] fr,
                                 input logic diag,
                                 input logic [15:0] cost_axis,
                                 input logic [15:0] cost_diag);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FLOOR, lo);
        write_reg(CFG_CEILING, hi);
        write_reg(CFG_FREE, fr);
        write_reg(CFG_DIAGONAL, {15'd0, diag});
        write_reg(CFG_COST_AXIS, cost_axis);
        write_reg(CFG_COST_DIAG, cost_diag);
        write_reg(CFG_UNUSED, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Returns once every predicted result has been taken from the engine.
    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_conf();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 5000)) - 2500);
        endcase
    endfunction

    // Mostly a small patch around the hot spot, so that marks and queries
    // meet; the rest on the grid border or anywhere.
    function automatic logic [6:0] pick_coord(input int hot);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1) ? 7'($urandom_range(0, 1))
                                                 : 7'(126 + $urandom_range(0, 1));
            2:       return 7'($urandom);
            default: return 7'(hot + int'($urandom_range(0, 3)));
        endcase
    endfunction

    task automatic random_item();
        int unsigned pick;
        logic [1:0]  func;
        pick = $urandom_range(0, 99);
        if (pick < 4 && sweeps_left > 0) begin
            func = (pick < 2) ? FUNC_DECAY : FUNC_CLEAR;
            sweeps_left--;
        end else if (pick < 52) begin
            func = FUNC_MARK;
        end else begin
            func = FUNC_QUERY;
        end
        send_command(func, pick_coord(hot_x), pick_coord(hot_y), rand_conf());
    endtask

    // Result side: a fresh stall is drawn after every transaction.
    initial begin
        int unsigned stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                stall = sink_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            else if (stall != 0)
                stall--;
            res_ch.ready <= (stall == 0) && i_rst_n;
        end
    end

    // Stimulus and verdict.
    initial begin
        int n_items;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_THRESHOLD;
        i_cfg_wdata       <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= FUNC_MARK;
        cmd_ch.cell_x     <= '0;
        cmd_ch.cell_y     <= '0;
        cmd_ch.confidence <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under the power-up settings.
        load_settings(16'sd0, -16'sd4096, 16'sd4096, -16'sd512, 1'b1, 16'd256, 16'd362);
        // Every cell sits at the blocking level, so the query finds nothing.
        send_command(FUNC_QUERY, 7'd10, 7'd10, rand_conf());
        send_command(FUNC_MARK, 7'd0, 7'd0, 16'sh8000);
        send_command(FUNC_MARK, 7'd127, 7'd127, 16'sh7FFF);
        send_command(FUNC_MARK, 7'd1, 7'd0, -16'sd1000);
        send_command(FUNC_MARK, 7'd0, 7'd1, -16'sd1000);
        send_command(FUNC_MARK, 7'd126, 7'd127, -16'sd1000);
        send_command(FUNC_MARK, 7'd127, 7'd126, -16'sd1000);
        send_command(FUNC_MARK, 7'd126, 7'd126, -16'sd1000);
        // Free the whole ring around one interior cell for a full answer.
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0)
                    send_command(FUNC_MARK, 7'(10 + dr), 7'(10 + dc), -16'sd1000);
        send_command(FUNC_QUERY, 7'd10, 7'd10, rand_conf());
        send_command(FUNC_QUERY, 7'd0, 7'd0, rand_conf());
        send_command(FUNC_QUERY, 7'd127, 7'd127, rand_conf());
        send_command(FUNC_QUERY, 7'd0, 7'd127, rand_conf());
        send_command(FUNC_DECAY, 7'($urandom), 7'($urandom), rand_conf());
        send_command(FUNC_QUERY, 7'd127, 7'd127, rand_conf());
        send_command(FUNC_CLEAR, 7'($urandom), 7'($urandom), rand_conf());
        send_command(FUNC_QUERY, 7'd10, 7'd10, rand_conf());
        cmd_ch.valid <= 1'b0;
        wait_drained();

        // Random phases; the first two hold the register extremes.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_settings(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0,
                                 16'd0, 16'hFFFF);
                // Floor above ceiling, and a level nothing can fall below.
                1: load_settings(16'sh8000, 16'sd2000, -16'sd2000, 16'sh7FFF, 1'b1,
                                 16'hFFFF, 16'd0);
                default: load_settings(16'(int'($urandom_range(0, 4000)) - 2000),
                                       16'(-int'($urandom_range(500, 6000))),
                                       16'(int'($urandom_range(500, 6000))),
                                       16'(int'($urandom_range(0, 3000)) - 1500),
                                       1'($urandom_range(0, 1)),
                                       16'($urandom), 16'($urandom));
            endcase
            hot_x   = ($urandom_range(0, 2) == 0) ? 124 * int'($urandom_range(0, 1))
                                                  : int'($urandom_range(0, 124));
            hot_y   = ($urandom_range(0, 2) == 0) ? 124 * int'($urandom_range(0, 1))
                                                  : int'($urandom_range(0, 124));
            n_items = (phase == 1) ? 20 : 48;
            for (int j = 0; j < n_items; j++) begin
                // Stretches with and without gaps on either side.
                if (j % 16 == 0) begin
                    src_idle_en  = ($urandom_range(0, 3) != 0);
                    sink_idle_en = ($urandom_range(0, 3) != 0);
                end
                random_item();
            end
            cmd_ch.valid <= 1'b0;
            wait_drained();
        end

        // Leave room for any stray result before the verdict.
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: 25 ms, several times the slowest correct run.
    initial begin
        #25_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
